// ===== rtl/pqh_pkg.sv =====
// Shared types, constants and elaboration-time functions for the PQ to scRGB half converter.
// The decode table builder here is evaluated only when the ROM is elaborated.
// No dependencies.
package pqh_pkg;

   localparam int LinearFracBitsDefault = 16;
   localparam int PixelWidth = 64;
   localparam int CodeWidth = 10;
   localparam int RomDepth = 1 << CodeWidth;
   localparam int RomWordWidth = 32;
   localparam int HalfWidth = 16;
   localparam int CoefWidth = 18;
   localparam int NumChannels = 3;

   localparam logic [HalfWidth-1:0] HalfOne = 16'h3C00;
   localparam logic [HalfWidth-2:0] HalfInfBits = 15'h7C00;

   localparam logic [63:0] Q32One = 64'h1_0000_0000;

   // BT.2020 to BT.709 matrix, signed Q16, row per output channel.
   localparam logic signed [CoefWidth-1:0] MatCoef [NumChannels][NumChannels] = '{
      '{ 18'sd108822, -18'sd38512, -18'sd4774 },
      '{ -18'sd8163, 18'sd74246, -18'sd547 },
      '{ -18'sd1190, -18'sd6592, 18'sd73317 }
   };

   typedef logic [RomWordWidth-1:0] pqh_rom_table_type [RomDepth];

   function automatic logic [63:0] pqh_isqrt(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bv;
      v = v_in;
      res = '0;
      bv = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bv > v) begin
            bv = bv >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (bv != '0) begin
            if (v >= res + bv) begin
               v = v - (res + bv);
               res = (res >> 1) + bv;
            end else begin
               res = res >> 1;
            end
            bv = bv >> 2;
         end
      end
      return res;
   endfunction

   // log2 of an integer, Q32 result.
   function automatic logic [63:0] pqh_log2(input logic [63:0] v);
      int k;
      logic [63:0] m;
      logic [63:0] res;
      k = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            k = i;
         end
      end
      if (k >= 31) begin
         m = v >> (k - 31);
      end else begin
         m = v << (31 - k);
      end
      res = 64'(k) << 32;
      for (int b = 31; b >= 0; b--) begin
         m = (m * m) >> 31;
         if (m >= Q32One) begin
            res[b] = 1'b1;
            m = m >> 1;
         end
      end
      return res;
   endfunction

   // 2 to the power of minus e, with e and the result in Q32.
   function automatic logic [63:0] pqh_exp2neg(input logic [63:0] e);
      logic [63:0] ipart;
      logic [63:0] y;
      ipart = e >> 32;
      y = Q32One;
      for (int j = 0; j < 32; j++) begin
         if (e[j]) begin
            y = y >> 1;
         end
         if (y < Q32One) begin
            y = pqh_isqrt(y << 32);
         end
      end
      if (ipart >= 64) begin
         return '0;
      end
      return y >> ipart;
   endfunction

   // Restoring division, one quotient bit per step.
   function automatic logic [63:0] pqh_udiv(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [RomWordWidth-1:0] pqh_entry(input logic [CodeWidth-1:0] code,
                                                        input int frac_bits);
      logic [63:0] lc;
      logic [63:0] lt;
      logic [63:0] neg;
      logic [63:0] p;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] r;
      logic [63:0] neg2;
      logic [63:0] y;
      logic [63:0] c1;
      c1 = 64'd3424 << 20;
      if (code == '0) begin
         return '0;
      end
      lc = pqh_log2(64'(code));
      lt = pqh_log2(64'd1023);
      neg = (lc >= lt) ? 64'd0 : lt - lc;
      p = pqh_exp2neg((neg * 32 + 64'd1261) / 2523);
      if (p <= c1) begin
         return '0;
      end
      num = p - c1;
      den = (64'd2413 << 25) - ((64'd2392 * p) >> 7);
      r = pqh_udiv(num << 32, den);
      if (r == '0) begin
         return '0;
      end
      if (r > Q32One) begin
         r = Q32One;
      end
      neg2 = (64'd32 << 32) - pqh_log2(r);
      y = pqh_exp2neg((neg2 * 16384 + 64'd1305) / 2610);
      return RomWordWidth'((64'd125 * y + (64'h1 << (31 - frac_bits))) >> (32 - frac_bits));
   endfunction

   function automatic pqh_rom_table_type pqh_build_rom(input int frac_bits);
      pqh_rom_table_type t;
      for (int code = 0; code < RomDepth; code++) begin
         t[code] = pqh_entry(CodeWidth'(code), frac_bits);
      end
      return t;
   endfunction

endpackage

// ===== rtl/pqh_if.sv =====
// Valid/ready channel interfaces for the PQ to scRGB half converter.
// Depends on pqh_pkg for the field widths.
interface pqh_req_if import pqh_pkg::*;;
   logic valid;
   logic ready;
   logic [PixelWidth-1:0] source_pixel;

   modport source (output valid, output source_pixel, input ready);
   modport sink (input valid, input source_pixel, output ready);
endinterface

interface pqh_rsp_if import pqh_pkg::*;;
   logic valid;
   logic ready;
   logic [HalfWidth-1:0] red_half;
   logic [HalfWidth-1:0] green_half;
   logic [HalfWidth-1:0] blue_half;
   logic [HalfWidth-1:0] alpha_half;

   modport source (output valid, output red_half, output green_half, output blue_half,
                   output alpha_half, input ready);
   modport sink (input valid, input red_half, input green_half, input blue_half,
                 input alpha_half, output ready);
endinterface

interface pqh_csr_if;
   logic valid;
   logic ready;
   logic source_is_fp16;

   modport source (output valid, output source_is_fp16, input ready);
   modport sink (input valid, input source_is_fp16, output ready);
endinterface

// ===== rtl/pq_hdr10_to_scrgb_half.sv =====
// Top level of the PQ HDR10 to linear scRGB half-float pixel converter.
// Depends on pqh_pkg, the channel interfaces, pqh_decode_rom and pqh_to_half.
//
// Usage:
//   req_bus carries one 64-bit pixel per request. With source_is_fp16 clear the
//   low 30 bits hold three 10-bit PQ codes (R, G, B from bit 0 up); each is
//   decoded through a ROM, passed through the BT.2020 to BT.709 matrix and
//   rounded to half, with alpha set to 1.0. With source_is_fp16 set the pixel is
//   already RGBA half and is passed through as it stands.
//   csr_bus writes source_is_fp16; it is always ready and should only be
//   written while no request is in flight.
//   rsp_bus returns one result per request, in order.
// Timing:
//   Five register stages: ROM read, matrix products, matrix sums, half
//   normalisation, output register. One request is taken every cycle as long
//   as the pipeline is not held by a stalled receiver.
//   When the receiver stalls, each stage still fills up behind the output
//   register, so requests keep being taken until every stage holds one.
// Reset clears all stage valid flags and source_is_fp16; no clearing pass.
module pq_hdr10_to_scrgb_half import pqh_pkg::*; #(
   parameter int LINEAR_FRAC_BITS = LinearFracBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   pqh_req_if.sink    req_bus,
   pqh_rsp_if.source  rsp_bus,
   pqh_csr_if.sink    csr_bus
);

   localparam int LinWidth = LINEAR_FRAC_BITS + 7;
   localparam int ProdWidth = LinWidth + 1 + CoefWidth;
   localparam int AccWidth = ProdWidth + 2;

   logic source_is_fp16_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   logic                  fp16_s1_ff, fp16_s2_ff, fp16_s3_ff, fp16_s4_ff;
   logic [PixelWidth-1:0] pix_s1_ff, pix_s2_ff, pix_s3_ff, pix_s4_ff;

   logic [LinWidth-1:0]         lin_s1 [NumChannels];
   logic signed [ProdWidth-1:0] prod_s2_ff [NumChannels][NumChannels];
   logic signed [AccWidth-1:0]  acc_s3_ff [NumChannels];
   logic [HalfWidth-1:0]        half_s4 [NumChannels];

   logic [HalfWidth-1:0] red_ff, green_ff, blue_ff, alpha_ff;

   // Each stage moves on when it is empty or its successor moves on.
   assign en5 = !v5_ff || rsp_bus.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_bus.ready = en1;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_is_fp16_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         source_is_fp16_ff <= csr_bus.source_is_fp16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   for (genvar c = 0; c < NumChannels; c++) begin : g_rom
      pqh_decode_rom #(
         .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)
      ) u_rom (
         .clock    (clock),
         .rd_enable(en1),
         .rd_addr  (req_bus.source_pixel[CodeWidth*c +: CodeWidth]),
         .rd_data  (lin_s1[c])
      );
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         fp16_s1_ff <= source_is_fp16_ff;
         pix_s1_ff <= req_bus.source_pixel;
      end
      if (en2) begin
         fp16_s2_ff <= fp16_s1_ff;
         pix_s2_ff <= pix_s1_ff;
         for (int r = 0; r < NumChannels; r++) begin
            for (int c = 0; c < NumChannels; c++) begin
               prod_s2_ff[r][c] <= ProdWidth'(MatCoef[r][c])
                                 * ProdWidth'($signed({1'b0, lin_s1[c]}));
            end
         end
      end
      if (en3) begin
         fp16_s3_ff <= fp16_s2_ff;
         pix_s3_ff <= pix_s2_ff;
         for (int r = 0; r < NumChannels; r++) begin
            acc_s3_ff[r] <= AccWidth'(prod_s2_ff[r][0]) + AccWidth'(prod_s2_ff[r][1])
                          + AccWidth'(prod_s2_ff[r][2]);
         end
      end
      if (en4) begin
         fp16_s4_ff <= fp16_s3_ff;
         pix_s4_ff <= pix_s3_ff;
      end
   end

   for (genvar c = 0; c < NumChannels; c++) begin : g_half
      pqh_to_half #(
         .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)
      ) u_to_half (
         .clock(clock),
         .load (en4),
         .acc  (acc_s3_ff[c]),
         .half (half_s4[c])
      );
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         if (fp16_s4_ff) begin
            red_ff <= pix_s4_ff[15:0];
            green_ff <= pix_s4_ff[31:16];
            blue_ff <= pix_s4_ff[47:32];
            alpha_ff <= pix_s4_ff[63:48];
         end else begin
            red_ff <= half_s4[0];
            green_ff <= half_s4[1];
            blue_ff <= half_s4[2];
            alpha_ff <= HalfOne;
         end
      end
   end

   assign rsp_bus.valid = v5_ff;
   assign rsp_bus.red_half = red_ff;
   assign rsp_bus.green_half = green_ff;
   assign rsp_bus.blue_half = blue_ff;
   assign rsp_bus.alpha_half = alpha_ff;

endmodule

// ===== rtl/pqh_decode_rom.sv =====
// PQ EOTF decode ROM, one registered read port.
// Contents are built at elaboration by pqh_pkg::pqh_build_rom.
module pqh_decode_rom import pqh_pkg::*; #(
   parameter int LINEAR_FRAC_BITS = LinearFracBitsDefault
) (
   input  logic                        clock,
   input  logic                        rd_enable,
   input  logic [CodeWidth-1:0]        rd_addr,
   output logic [LINEAR_FRAC_BITS+6:0] rd_data
);

   localparam int LinWidth = LINEAR_FRAC_BITS + 7;
   localparam pqh_rom_table_type RomTable = pqh_build_rom(LINEAR_FRAC_BITS);

   logic [LinWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_enable) begin
         rd_data_ff <= RomTable[rd_addr][LinWidth-1:0];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pqh_to_half.sv =====
// Signed fixed-point to IEEE half conversion, round to nearest even.
// One register stage holds magnitude and leading-one position; rounding follows it.
module pqh_to_half import pqh_pkg::*; #(
   parameter int LINEAR_FRAC_BITS = LinearFracBitsDefault
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic signed [LINEAR_FRAC_BITS+27:0] acc,
   output logic [HalfWidth-1:0]         half
);

   localparam int AccWidth = LINEAR_FRAC_BITS + 28;
   localparam int Scale = LINEAR_FRAC_BITS + 16;
   localparam int TopWidth = $clog2(AccWidth);
   localparam int ExpWidth = TopWidth + 1;

   logic [AccWidth-1:0] mag_in;
   logic [TopWidth-1:0] top_in;
   logic                sign_ff;
   logic [AccWidth-1:0] mag_ff;
   logic [TopWidth-1:0] top_ff;

   logic                subnormal;
   logic [TopWidth-1:0] shift;
   logic [AccWidth-1:0] quot;
   logic [AccWidth-1:0] low_mask;
   logic                guard;
   logic                sticky;
   logic                round_up;
   logic [11:0]         rounded;
   logic [ExpWidth-1:0] exponent;
   logic [HalfWidth-2:0] bits;

   always_comb begin
      mag_in = acc[AccWidth-1] ? AccWidth'(-acc) : AccWidth'(acc);
      top_in = '0;
      for (int i = 0; i < AccWidth; i++) begin
         if (mag_in[i]) begin
            top_in = TopWidth'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sign_ff <= acc[AccWidth-1];
         mag_ff <= mag_in;
         top_ff <= top_in;
      end
   end

   // Values below the smallest normal half keep a fixed scale; a zero lands here too.
   always_comb begin
      subnormal = top_ff < TopWidth'(Scale - 14);
      shift = subnormal ? TopWidth'(Scale - 24) : top_ff - TopWidth'(10);
      quot = mag_ff >> shift;
      low_mask = (AccWidth'(1) << (shift - TopWidth'(1))) - AccWidth'(1);
      guard = mag_ff[shift - TopWidth'(1)];
      sticky = |(mag_ff & low_mask);
      round_up = guard && (sticky || quot[0]);
      rounded = quot[11:0] + 12'(round_up);
      exponent = ExpWidth'(top_ff) - ExpWidth'(Scale - 15) + ExpWidth'(rounded[11]);
      if (subnormal) begin
         bits = (HalfWidth-1)'(rounded);
      end else if (exponent >= ExpWidth'(31)) begin
         bits = HalfInfBits;
      end else begin
         bits = {exponent[4:0], rounded[11] ? 10'd0 : rounded[9:0]};
      end
      half = {sign_ff, bits};
   end

endmodule
